### design/mie_pkg.sv
// Shared package for the extended-Euclid modular inverse block.
// Holds default sizing, the modulus reset value and controller/datapath structs.
// No dependencies.
package mie_pkg;

  localparam int unsigned DefaultWidth = 32;
  localparam logic [63:0] ModulusReset = 64'd1000000007;

  typedef struct packed {
    logic load;
    logic up;
    logic down;
    logic swap;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic dbl_le;
    logic k_zero;
    logic rem_zero;
  } status_t;

endpackage

### design/mie_ctrl.sv
// Controller for the modular inverse block: sequences shift-align and
// subtract steps of each Euclid division. Depends on mie_pkg.
module mie_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             done_o,
  input  mie_pkg::status_t status_i,
  output mie_pkg::cmd_t    cmd_o
);
  import mie_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StAlign,
    StSub,
    StFin
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.m_zero ? StFin : StAlign;
        end
      end
      StAlign: begin
        if (status_i.dbl_le) begin
          cmd_o.up = 1'b1;
        end else begin
          state_d = StSub;
        end
      end
      StSub: begin
        if (status_i.k_zero) begin
          cmd_o.swap = 1'b1;
          state_d    = status_i.rem_zero ? StFin : StAlign;
        end else begin
          cmd_o.down = 1'b1;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;

endmodule

### design/mie_dp.sv
// Datapath for the modular inverse block: modulus register, remainder pair,
// coefficient pair, shifted divisor and result registers. Depends on mie_pkg.
module mie_dp #(
  parameter int unsigned WIDTH = mie_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_wdata_i,
  input  logic [WIDTH-1:0] value_i,
  input  mie_pkg::cmd_t    cmd_i,
  output mie_pkg::status_t status_o,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);
  import mie_pkg::*;

  localparam int unsigned KW = $clog2(WIDTH);

  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d, d_q, d_d, tk_q, tk_d, t0_q, t0_d, t1_q, t1_d;
  logic [WIDTH-1:0] inv_q, inv_d;
  logic [KW-1:0]    k_q, k_d;
  logic             odd_q, odd_d, first_q, first_d, none_q, none_d;

  logic             sub_ok;
  logic [WIDTH-1:0] a_sub, t_sub;

  assign sub_ok = (d_q <= a_q);
  assign a_sub  = sub_ok ? (a_q - d_q) : a_q;
  assign t_sub  = sub_ok ? (t0_q + tk_q) : t0_q;

  assign status_o.m_zero   = (mod_q == '0);
  assign status_o.dbl_le   = ({d_q, 1'b0} <= {1'b0, a_q});
  assign status_o.k_zero   = (k_q == '0);
  assign status_o.rem_zero = (a_sub == '0);

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    tk_d    = tk_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    k_d     = k_q;
    odd_d   = odd_q;
    first_d = first_q;
    inv_d   = inv_q;
    none_d  = none_q;
    if (cmd_i.load) begin
      a_d     = value_i;
      b_d     = mod_q;
      d_d     = mod_q;
      tk_d    = '0;
      t0_d    = WIDTH'(1);
      t1_d    = '0;
      k_d     = '0;
      odd_d   = 1'b0;
      first_d = 1'b1;
    end
    if (cmd_i.up) begin
      d_d  = {d_q[WIDTH-2:0], 1'b0};
      tk_d = {tk_q[WIDTH-2:0], 1'b0};
      k_d  = k_q + KW'(1);
    end
    if (cmd_i.down) begin
      a_d  = a_sub;
      t0_d = t_sub;
      d_d  = {1'b0, d_q[WIDTH-1:1]};
      tk_d = {1'b0, tk_q[WIDTH-1:1]};
      k_d  = k_q - KW'(1);
    end
    if (cmd_i.swap) begin
      // remainder becomes the new divisor; the first division only reduces
      a_d     = b_q;
      b_d     = a_sub;
      d_d     = a_sub;
      t0_d    = t1_q;
      t1_d    = t_sub;
      tk_d    = t_sub;
      k_d     = '0;
      odd_d   = first_q ? odd_q : !odd_q;
      first_d = 1'b0;
    end
    if (cmd_i.finish) begin
      none_d = status_o.m_zero || (a_q != WIDTH'(1));
      if (none_d) begin
        inv_d = '0;
      end else if (odd_q || (t0_q == '0)) begin
        inv_d = t0_q;
      end else begin
        inv_d = mod_q - t0_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= ModulusReset[WIDTH-1:0];
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    d_q     <= d_d;
    tk_q    <= tk_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    k_q     <= k_d;
    odd_q   <= odd_d;
    first_q <= first_d;
    inv_q   <= inv_d;
    none_q  <= none_d;
  end

  assign inverse_o    = inv_q;
  assign no_inverse_o = none_q;

endmodule

### design/modular_inverse_ext_euclid.sv
// Modular inverse by extended Euclid: one item at a time, busy high while working.
// Each division runs in the shift-align / shift-subtract unit: the divisor is shifted up
// until aligned, then back down with a conditional subtract; the first division reduces the operand.
// done_o pulses one cycle with the result; the receiver cannot stall.
// Async active-low reset: controller idle, modulus back to 1000000007.
module modular_inverse_ext_euclid #(
  parameter int unsigned WIDTH = mie_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIDTH-1:0] cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] value_i,
  output logic             done_o,
  output logic [WIDTH-1:0] inverse_o,
  output logic             no_inverse_o
);
  import mie_pkg::*;

  cmd_t    cmd;
  status_t status;

  mie_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mie_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .inverse_o    (inverse_o),
    .no_inverse_o (no_inverse_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside end of item");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && no_inverse_o |-> inverse_o == '0)
    else $error("nonzero inverse with no-inverse flag");

endmodule
